[design/ptr3_pkg.sv]
`timescale 1ns / 1ps
// shared constants, widths and codes for the 3d point reflection core
// no dependencies

package ptr3_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // widths derived from the coordinate width
    localparam int DIR_W   = COORD_WIDTH + 1;          // direction and offset vectors
    localparam int BASE_W  = COORD_WIDTH + 2;          // 2u-p, 2w-p or p
    localparam int PROD_W  = 2 * DIR_W;                // one coordinate product
    localparam int NUM_W   = PROD_W + 2;               // dot products and numerator
    localparam int HALF_W  = NUM_W / 2;                // low slice of |num|
    localparam int HI_W    = NUM_W - HALF_W;           // high slice of |num|
    localparam int MAG_W   = DIR_W + NUM_W;            // |dir_k| * |num|
    localparam int QUO_W   = COORD_WIDTH + 2;          // quotient bits kept
    localparam int DEN_W   = NUM_W + 1;                // 2 * |dir|^2
    localparam int REM_W   = DEN_W + QUO_W;            // dividend and remainder
    localparam int RES_W   = COORD_WIDTH + 5;          // unsaturated result

    localparam int IN_TDATA_W  = ((10 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_POINT = 2'd0,
        OP_LINE  = 2'd1,
        OP_PLANE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_SAT   = 2'd2
    } status_t;

endpackage

[design/point_reflection_3d_core.sv]
`timescale 1ns / 1ps
// 3d point reflection across a point, a line or a plane, q16.16 coordinates
// depends on ptr3_pkg

// Takes one point per clock while the output is not held and returns one result
// per point, in order. The latency is set mostly by the restoring divider, one
// pipeline stage per quotient bit, which forms the rounded term
// 2*dir_k*num/|dir|^2 for the three axes side by side.
// Products are split so that no multiplier is wider than 33 by 34 bits. When
// the output beat is not taken the whole pipeline holds; s_axis_tready is low
// only while a finished beat waits at the output.
module point_reflection_3d_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // px, py, pz, ux, uy, uz, wx, wy, wz, plane_offset
    input  logic [ptr3_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // opcode
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // rx, ry, rz
    output logic [ptr3_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // status
    output logic [1:0]                        m_axis_tuser
);

    import ptr3_pkg::*;

    localparam logic signed [RES_W-1:0] RES_MAX =
        {{(RES_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [RES_W-1:0] RES_MIN =
        {{(RES_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic                         pass;    // reflection across a point
        logic                         plane;
        logic                         degen;
        logic [2:0][BASE_W-1:0]       base;
    } ctl_t;

    logic en;

    // ---------------------------------------------------------------
    // stage 1: unpack, differences, base term
    // ---------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] p_in [3];
    logic signed [COORD_WIDTH-1:0] u_in [3];
    logic signed [COORD_WIDTH-1:0] w_in [3];
    logic signed [COORD_WIDTH-1:0] d_in;

    logic                     s1_vld_reg;
    ctl_t                     s1_ctl_reg, s1_ctl_next;
    logic signed [DIR_W-1:0]  s1_dir_reg [3];
    logic signed [DIR_W-1:0]  s1_dir_next [3];
    logic signed [DIR_W-1:0]  s1_vec_reg [3];
    logic signed [DIR_W-1:0]  s1_vec_next [3];
    logic signed [NUM_W-1:0]  s1_off_reg, s1_off_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            p_in[k] = s_axis_tdata[k*COORD_WIDTH +: COORD_WIDTH];
            u_in[k] = s_axis_tdata[(3+k)*COORD_WIDTH +: COORD_WIDTH];
            w_in[k] = s_axis_tdata[(6+k)*COORD_WIDTH +: COORD_WIDTH];
        end
        d_in = s_axis_tdata[9*COORD_WIDTH +: COORD_WIDTH];
    end

    always_comb
    begin
        s1_ctl_next.pass  = (s_axis_tuser == OP_POINT);
        s1_ctl_next.plane = (s_axis_tuser == OP_PLANE);
        s1_ctl_next.degen = !((s_axis_tuser == OP_POINT) || (s_axis_tuser == OP_LINE)
                              || (s_axis_tuser == OP_PLANE));
        for (int k = 0; k < 3; k++)
        begin
            if (s_axis_tuser == OP_LINE)
            begin
                s1_dir_next[k] = DIR_W'(w_in[k]) - DIR_W'(u_in[k]);
                s1_vec_next[k] = DIR_W'(p_in[k]) - DIR_W'(w_in[k]);
                s1_ctl_next.base[k] = (BASE_W'(w_in[k]) <<< 1) - BASE_W'(p_in[k]);
            end
            else if (s_axis_tuser == OP_POINT)
            begin
                s1_dir_next[k] = DIR_W'(u_in[k]);
                s1_vec_next[k] = DIR_W'(p_in[k]);
                s1_ctl_next.base[k] = (BASE_W'(u_in[k]) <<< 1) - BASE_W'(p_in[k]);
            end
            else
            begin
                s1_dir_next[k] = DIR_W'(u_in[k]);
                s1_vec_next[k] = DIR_W'(p_in[k]);
                s1_ctl_next.base[k] = BASE_W'(p_in[k]);
            end
        end
        s1_off_next = NUM_W'(d_in) <<< FRAC_BITS;
    end

    // ---------------------------------------------------------------
    // stage 2: coordinate products
    // ---------------------------------------------------------------
    logic                      s2_vld_reg;
    ctl_t                      s2_ctl_reg;
    logic signed [DIR_W-1:0]   s2_dir_reg [3];
    logic signed [PROD_W-1:0]  s2_pr_reg [3];
    logic signed [PROD_W-1:0]  s2_sq_reg [3];
    logic signed [NUM_W-1:0]   s2_off_reg;

    // ---------------------------------------------------------------
    // stage 3: dot products
    // ---------------------------------------------------------------
    logic                      s3_vld_reg;
    ctl_t                      s3_ctl_reg;
    logic signed [DIR_W-1:0]   s3_dir_reg [3];
    logic signed [NUM_W-1:0]   s3_num_reg, s3_num_next;
    logic signed [NUM_W-1:0]   s3_n2_reg, s3_n2_next;

    always_comb
    begin
        s3_n2_next  = NUM_W'(s2_sq_reg[0]) + NUM_W'(s2_sq_reg[1]) + NUM_W'(s2_sq_reg[2]);
        s3_num_next = NUM_W'(s2_pr_reg[0]) + NUM_W'(s2_pr_reg[1]) + NUM_W'(s2_pr_reg[2]);
        if (s2_ctl_reg.plane)
        begin
            s3_num_next = s2_off_reg - s3_num_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 4: magnitudes and signs, zero length check
    // ---------------------------------------------------------------
    logic                      s4_vld_reg;
    ctl_t                      s4_ctl_reg, s4_ctl_next;
    logic [DIR_W-1:0]          s4_adir_reg [3];
    logic [2:0]                s4_neg_reg;
    logic [NUM_W-1:0]          s4_anum_reg;
    logic [NUM_W-1:0]          s4_n2_reg;

    always_comb
    begin
        s4_ctl_next       = s3_ctl_reg;
        s4_ctl_next.degen = s3_ctl_reg.degen || (!s3_ctl_reg.pass && (s3_n2_reg == '0));
    end

    // ---------------------------------------------------------------
    // stage 5: partial products |dir_k| * |num|
    // ---------------------------------------------------------------
    logic                          s5_vld_reg;
    ctl_t                          s5_ctl_reg;
    logic [2:0]                    s5_neg_reg;
    logic [NUM_W-1:0]              s5_n2_reg;
    logic [DIR_W+HALF_W-1:0]       s5_lo_reg [3];
    logic [DIR_W+HI_W-1:0]         s5_hi_reg [3];

    // ---------------------------------------------------------------
    // stage 6: full product
    // ---------------------------------------------------------------
    logic                      s6_vld_reg;
    ctl_t                      s6_ctl_reg;
    logic [2:0]                s6_neg_reg;
    logic [NUM_W-1:0]          s6_n2_reg;
    logic [MAG_W-1:0]          s6_mag_reg [3];

    // ---------------------------------------------------------------
    // stage 7: rounded dividend 4*mag + n2 and divisor 2*n2
    // ---------------------------------------------------------------
    logic                      s7_vld_reg;
    ctl_t                      s7_ctl_reg;
    logic [2:0]                s7_neg_reg;
    logic [DEN_W-1:0]          s7_den_reg;
    logic [REM_W-1:0]          s7_nn_reg [3];

    // ---------------------------------------------------------------
    // divider: entry 0 holds the overflow check, then one bit a stage
    // ---------------------------------------------------------------
    logic                      dv_vld_reg [QUO_W+1];
    ctl_t                      dv_ctl_reg [QUO_W+1];
    logic [2:0]                dv_neg_reg [QUO_W+1];
    logic [2:0]                dv_ovf_reg [QUO_W+1];
    logic [DEN_W-1:0]          dv_den_reg [QUO_W+1];
    logic [REM_W-1:0]          dv_rem_reg [QUO_W+1][3];
    logic [QUO_W-1:0]          dv_quo_reg [QUO_W+1][3];

    // stage registers up to the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s4_vld_reg    <= 1'b0;
            s5_vld_reg    <= 1'b0;
            s6_vld_reg    <= 1'b0;
            s7_vld_reg    <= 1'b0;
            dv_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg    <= s_axis_tvalid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s4_vld_reg    <= s3_vld_reg;
            s5_vld_reg    <= s4_vld_reg;
            s6_vld_reg    <= s5_vld_reg;
            s7_vld_reg    <= s6_vld_reg;
            dv_vld_reg[0] <= s7_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ctl_reg <= s1_ctl_next;
            s1_off_reg <= s1_off_next;
            s2_ctl_reg <= s1_ctl_reg;
            s2_off_reg <= s1_off_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s3_num_reg <= s3_num_next;
            s3_n2_reg  <= s3_n2_next;
            s4_ctl_reg <= s4_ctl_next;
            s4_anum_reg <= s3_num_reg[NUM_W-1] ? $unsigned(-s3_num_reg)
                                               : $unsigned(s3_num_reg);
            s4_n2_reg  <= $unsigned(s3_n2_reg);
            s5_ctl_reg <= s4_ctl_reg;
            s5_neg_reg <= s4_neg_reg;
            s5_n2_reg  <= s4_n2_reg;
            s6_ctl_reg <= s5_ctl_reg;
            s6_neg_reg <= s5_neg_reg;
            s6_n2_reg  <= s5_n2_reg;
            s7_ctl_reg <= s6_ctl_reg;
            s7_neg_reg <= s6_neg_reg;
            s7_den_reg <= DEN_W'(s6_n2_reg) << 1;
            dv_ctl_reg[0] <= s7_ctl_reg;
            dv_neg_reg[0] <= s7_neg_reg;
            dv_den_reg[0] <= s7_den_reg;
            for (int k = 0; k < 3; k++)
            begin
                s1_dir_reg[k] <= s1_dir_next[k];
                s1_vec_reg[k] <= s1_vec_next[k];
                s2_dir_reg[k] <= s1_dir_reg[k];
                s2_pr_reg[k]  <= s1_dir_reg[k] * s1_vec_reg[k];
                s2_sq_reg[k]  <= s1_dir_reg[k] * s1_dir_reg[k];
                s3_dir_reg[k] <= s2_dir_reg[k];
                s4_adir_reg[k] <= s3_dir_reg[k][DIR_W-1] ? $unsigned(-s3_dir_reg[k])
                                                         : $unsigned(s3_dir_reg[k]);
                s4_neg_reg[k] <= s3_dir_reg[k][DIR_W-1] ^ s3_num_reg[NUM_W-1];
                s5_lo_reg[k]  <= s4_adir_reg[k] * s4_anum_reg[HALF_W-1:0];
                s5_hi_reg[k]  <= s4_adir_reg[k] * s4_anum_reg[NUM_W-1:HALF_W];
                s6_mag_reg[k] <= (MAG_W'(s5_hi_reg[k]) << HALF_W) + MAG_W'(s5_lo_reg[k]);
                s7_nn_reg[k]  <= (REM_W'(s6_mag_reg[k]) << 2) + REM_W'(s6_n2_reg);
                // quotient would not fit: the result saturates whatever its low bits
                dv_ovf_reg[0][k] <= (s7_nn_reg[k] >= (REM_W'(s7_den_reg) << QUO_W));
                dv_rem_reg[0][k] <= s7_nn_reg[k];
                dv_quo_reg[0][k] <= '0;
            end
        end
    end

    // restoring division, bit QUO_W-1-j decided in stage j
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        localparam int BIT = QUO_W - 1 - j;
        logic [REM_W-1:0] sub_den;
        logic [REM_W-1:0] rem_next [3];
        logic [QUO_W-1:0] quo_next [3];

        always_comb
        begin
            sub_den = REM_W'(dv_den_reg[j]) << BIT;
            for (int k = 0; k < 3; k++)
            begin
                rem_next[k] = dv_rem_reg[j][k];
                quo_next[k] = dv_quo_reg[j][k];
                if (dv_rem_reg[j][k] >= sub_den)
                begin
                    rem_next[k]      = dv_rem_reg[j][k] - sub_den;
                    quo_next[k][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_vld_reg[j+1] <= dv_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_ctl_reg[j+1] <= dv_ctl_reg[j];
                dv_neg_reg[j+1] <= dv_neg_reg[j];
                dv_ovf_reg[j+1] <= dv_ovf_reg[j];
                dv_den_reg[j+1] <= dv_den_reg[j];
                for (int k = 0; k < 3; k++)
                begin
                    dv_rem_reg[j+1][k] <= rem_next[k];
                    dv_quo_reg[j+1][k] <= quo_next[k];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // output stage: add, saturate, status
    // ---------------------------------------------------------------
    ctl_t                          fin_ctl;
    logic [QUO_W:0]                fin_q [3];
    logic signed [RES_W-1:0]       fin_res [3];
    logic [2:0]                    fin_sat;

    logic                          m_vld_reg;
    logic [COORD_WIDTH-1:0]        m_data_reg [3];
    logic [COORD_WIDTH-1:0]        m_data_next [3];
    status_t                       m_status_reg, m_status_next;

    assign fin_ctl = dv_ctl_reg[QUO_W];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            fin_q[k] = dv_ovf_reg[QUO_W][k] ? {1'b1, {QUO_W{1'b0}}}
                                            : {1'b0, dv_quo_reg[QUO_W][k]};
            fin_res[k] = RES_W'($signed(fin_ctl.base[k]));
            if (!fin_ctl.pass)
            begin
                if (dv_neg_reg[QUO_W][k])
                begin
                    fin_res[k] = fin_res[k] - $signed(RES_W'(fin_q[k]));
                end
                else
                begin
                    fin_res[k] = fin_res[k] + $signed(RES_W'(fin_q[k]));
                end
            end
            fin_sat[k] = 1'b0;
            if (fin_res[k] > RES_MAX)
            begin
                m_data_next[k] = COORD_MAX;
                fin_sat[k]     = 1'b1;
            end
            else if (fin_res[k] < RES_MIN)
            begin
                m_data_next[k] = COORD_MIN;
                fin_sat[k]     = 1'b1;
            end
            else
            begin
                m_data_next[k] = fin_res[k][COORD_WIDTH-1:0];
            end
            if (fin_ctl.degen)
            begin
                m_data_next[k] = '0;
            end
        end
        if (fin_ctl.degen)
        begin
            m_status_next = ST_DEGEN;
        end
        else if (fin_sat != 3'b000)
        begin
            m_status_next = ST_SAT;
        end
        else
        begin
            m_status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m_vld_reg <= dv_vld_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_status_reg <= m_status_next;
            for (int k = 0; k < 3; k++)
            begin
                m_data_reg[k] <= m_data_next[k];
            end
        end
    end

    // handshake: the pipeline advances unless a beat waits at the output
    assign en            = !m_vld_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tuser  = m_status_reg;

    always_comb
    begin
        m_axis_tdata = '0;
        for (int k = 0; k < 3; k++)
        begin
            m_axis_tdata[k*COORD_WIDTH +: COORD_WIDTH] = m_data_reg[k];
        end
    end

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // degenerate beats carry a zero point
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_DEGEN)) |-> (m_axis_tdata == '0))
        else $error("degenerate beat with nonzero point");

    // a saturated beat has at least one clamped coordinate
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_SAT)) |->
            ((m_data_reg[0] == COORD_MAX) || (m_data_reg[0] == COORD_MIN) ||
             (m_data_reg[1] == COORD_MAX) || (m_data_reg[1] == COORD_MIN) ||
             (m_data_reg[2] == COORD_MAX) || (m_data_reg[2] == COORD_MIN)))
        else $error("saturated status without a clamped coordinate");

    // a held output freezes the pipeline valids
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            ($stable(s4_vld_reg) && $stable(dv_vld_reg[QUO_W])))
        else $error("pipeline moved during an output stall");

endmodule

[tb/sv/tb_point_reflection_3d_core.sv]
`timescale 1ns / 1ps
// regression bench for point_reflection_3d_core: directed and random points
// depends on ptr3_pkg and the core; predicts reflections with wide exact math

module tb_point_reflection_3d_core;
    import ptr3_pkg::*;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int W = COORD_WIDTH;

    typedef logic signed [191:0] big_t;

    typedef struct {
        logic [W-1:0] rx;
        logic [W-1:0] ry;
        logic [W-1:0] rz;
        status_t      st;
    } mirror_t;

    // scoreboard: predicts each reflection and checks results in order
    class reflection_board;
        mirror_t expected_q[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        // n/d rounded to nearest, ties away from zero
        function big_t round_div(big_t n, big_t d);
            big_t an;
            big_t ad;
            big_t q;
            an = (n < 0) ? -n : n;
            ad = (d < 0) ? -d : d;
            q  = (2 * an + ad) / (2 * ad);
            return ((n < 0) != (d < 0)) ? -q : q;
        endfunction

        function void clamp(big_t v, output logic [W-1:0] r, inout bit sat);
            big_t maxv;
            big_t minv;
            maxv = (big_t'(1) <<< (W - 1)) - 1;
            minv = -(big_t'(1) <<< (W - 1));
            if (v > maxv) begin
                r   = maxv[W-1:0];
                sat = 1;
            end
            else if (v < minv) begin
                r   = minv[W-1:0];
                sat = 1;
            end
            else
                r = v[W-1:0];
        endfunction

        function void note_point(logic [1:0] op, logic [IN_TDATA_W-1:0] data);
            big_t p[3];
            big_t u[3];
            big_t w[3];
            big_t dir[3];
            big_t res[3];
            big_t num;
            big_t len2;
            big_t d;
            mirror_t m;
            bit sat;
            sat = 0;
            for (int k = 0; k < 3; k++)
            begin
                p[k] = big_t'($signed(data[k*W +: W]));
                u[k] = big_t'($signed(data[(3+k)*W +: W]));
                w[k] = big_t'($signed(data[(6+k)*W +: W]));
            end
            d = big_t'($signed(data[9*W +: W]));
            m = '{rx: '0, ry: '0, rz: '0, st: ST_DEGEN};
            if (op == OP_RESERVED) begin
                expected_q.push_back(m);
                return;
            end
            if (op == OP_POINT) begin
                for (int k = 0; k < 3; k++)
                    res[k] = 2 * u[k] - p[k];
            end
            else begin
                num = 0;
                for (int k = 0; k < 3; k++)
                begin
                    dir[k] = (op == OP_LINE) ? w[k] - u[k] : u[k];
                    if (op == OP_LINE)
                        num += (p[k] - w[k]) * dir[k];
                    else
                        num -= dir[k] * p[k];
                end
                if (op == OP_PLANE)
                    num += d <<< FRAC_BITS;
                len2 = dir[0] * dir[0] + dir[1] * dir[1] + dir[2] * dir[2];
                if (len2 == 0) begin
                    expected_q.push_back(m);
                    return;
                end
                for (int k = 0; k < 3; k++)
                    res[k] = ((op == OP_LINE) ? 2 * w[k] - p[k] : p[k])
                           + round_div(2 * dir[k] * num, len2);
            end
            clamp(res[0], m.rx, sat);
            clamp(res[1], m.ry, sat);
            clamp(res[2], m.rz, sat);
            m.st = sat ? ST_SAT : ST_OK;
            expected_q.push_back(m);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic [1:0] st);
            mirror_t m;
            if (expected_q.size() == 0) begin
                $error("unexpected result beat: %h status %0d", data, st);
                errors++;
                return;
            end
            m = expected_q.pop_front();
            if (data[0 +: W] !== m.rx) begin
                $error("rx expected %h actual %h", m.rx, data[0 +: W]);
                errors++;
            end
            if (data[W +: W] !== m.ry) begin
                $error("ry expected %h actual %h", m.ry, data[W +: W]);
                errors++;
            end
            if (data[2*W +: W] !== m.rz) begin
                $error("rz expected %h actual %h", m.rz, data[2*W +: W]);
                errors++;
            end
            if (st !== m.st) begin
                $error("status expected %0d actual %0d", m.st, st);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;

    reflection_board board;
    bit              calm;

    point_reflection_3d_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // hard stop
    initial
    begin
        #10ms;
        $display("point_reflection_3d_core regression: fail");
        $finish;
    end

    // receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 31);
    end

    // watch both sides for accepted beats
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            board.note_point(s_axis_tuser, s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser);
    end

    // random coordinate: mostly moderate, some small, some extreme
    function automatic logic [W-1:0] pick_coord();
        case ($urandom_range(9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return W'($signed($urandom_range(8)) - 4) <<< FRAC_BITS;
            3, 4: return $urandom;
            default: return W'($signed($urandom_range(32'h00ffffff)) - 32'sh007fffff);
        endcase
    endfunction

    task automatic send_point(logic [1:0] op, logic [IN_TDATA_W-1:0] data);
        // each cycle idles with the same chance
        while (!calm && $urandom_range(99) < 31) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_random(int n);
        logic [IN_TDATA_W-1:0] data;
        logic [1:0]            op;
        for (int i = 0; i < n; i++)
        begin
            for (int k = 0; k < 10; k++)
                data[k*W +: W] = pick_coord();
            op = ($urandom_range(19) == 0) ? OP_RESERVED : 2'($urandom_range(2));
            // degenerate line or plane now and then
            if ($urandom_range(24) == 0) begin
                if (op == OP_LINE)
                    data[6*W +: 3*W] = data[3*W +: 3*W];
                else
                    data[3*W +: 3*W] = '0;
            end
            send_point(op, data);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [IN_TDATA_W-1:0] pack(logic [W-1:0] v[10]);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        for (int k = 0; k < 10; k++)
            d[k*W +: W] = v[k];
        return d;
    endfunction

    localparam logic [W-1:0] ONE  = 32'h00010000;
    localparam logic [W-1:0] MAXC = 32'h7fffffff;
    localparam logic [W-1:0] MINC = 32'h80000000;

    initial
    begin
        board         = new();
        calm          = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_POINT;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every opcode, extremes, degenerate and saturating cases
        send_point(OP_POINT, pack('{ONE, 2*ONE, 3*ONE, 0, 0, 0, 0, 0, 0, 0}));
        send_point(OP_POINT, pack('{MINC, MINC, MINC, MAXC, MAXC, MAXC, 0, 0, 0, 0}));
        send_point(OP_POINT, pack('{MAXC, MINC, 0, MINC, MAXC, 0, 0, 0, 0, 0}));
        send_point(OP_POINT, pack('{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 0, 0, 0, 0}));
        send_point(OP_LINE, pack('{ONE, ONE, 0, 0, 0, 0, ONE, 0, 0, 0}));
        send_point(OP_LINE, pack('{ONE, 2*ONE, 3*ONE, ONE, ONE, ONE, ONE, ONE, ONE, 0}));
        send_point(OP_LINE, pack('{ONE, 0, 0, 0, 0, 0, 3, 3, 0, 0}));
        send_point(OP_LINE, pack('{MAXC, MAXC, MAXC, MINC, MINC, MINC,
                                    MAXC, MINC, MAXC, 0}));
        send_point(OP_LINE, pack('{MINC, MAXC, MINC, MAXC, MAXC, MAXC,
                                    MINC, MINC, MINC, MAXC}));
        send_point(OP_PLANE, pack('{ONE, ONE, ONE, 0, 0, ONE, 0, 0, 0, 0}));
        send_point(OP_PLANE, pack('{ONE, 2*ONE, 3*ONE, 0, 0, 0, 0, 0, 0, ONE}));
        send_point(OP_PLANE, pack('{ONE, 0, 0, 1, 1, 1, 0, 0, 0, 1}));
        send_point(OP_PLANE, pack('{3, 0, 0, 2, 0, 0, 0, 0, 0, 0}));
        send_point(OP_PLANE, pack('{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
                                    0, 0, 0, MINC}));
        send_point(OP_PLANE, pack('{MINC, MINC, MINC, MINC, MINC, MINC,
                                    MAXC, MAXC, MAXC, MAXC}));
        send_point(OP_PLANE, pack('{MINC, MAXC, 0, 1, 0, 0, 0, 0, 0, MAXC}));
        send_point(OP_RESERVED, pack('{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE}));
        send_point(OP_RESERVED, '1);
        send_point(OP_POINT, '1);
        send_point(OP_LINE, '1);
        send_point(OP_PLANE, '1);

        send_random(600);
        // stretch without idling on either side
        calm = 1'b1;
        send_random(300);
        calm = 1'b0;
        // sender holds off until everything has come back
        wait_drained();
        send_random(850);

        wait_drained();
        repeat (60) @(posedge clk);
        if (board.errors == 0 && board.expected_q.size() == 0)
            $display("point_reflection_3d_core regression: pass");
        else
            $display("point_reflection_3d_core regression: fail");
        $finish;
    end
endmodule
